/* rtl/dlpp_pkg.sv */
package dlpp_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int FILL_W = ADDR_W + 1;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // classified word handed from the front to the back
   typedef struct packed {
      logic              is_read;
      logic              is_delim;
      logic [BYTE_W-1:0] data;
   } op_type;

   typedef struct packed {
      logic out_valid;
      logic out_last;
      logic line_done;
      logic overflow;
      logic back_empty;
   } flags_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      flags_type         flags;
   } rsp_type;

endpackage

/* rtl/dlpp_ram.sv */
module dlpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dlpp_front.sv */
module dlpp_front
   import dlpp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_func,
   input  logic [BYTE_W-1:0] req_byte,
   output logic              op_valid,
   output op_type            op,
   input  logic              op_pop
);

   logic [BYTE_W-1:0] delimiter_ff;
   op_type            q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;
   op_type            op_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIM_RESET;
      end else if (csr_wr_en) begin
         delimiter_ff <= csr_wr_data;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      op_new.is_read  = (req_func == FUNC_READ);
      op_new.is_delim = (req_byte == delimiter_ff);
      op_new.data     = req_byte;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = op_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, op_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

   assign op_valid = (cnt_ff != 2'd0);
   assign op       = q_ff[rd_ptr_ff];

endmodule

/* rtl/dlpp_back.sv */
module dlpp_back
   import dlpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op,
   output logic    op_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [FILL_W-1:0] fill_a_ff, fill_a_in;
   logic [FILL_W-1:0] fill_b_ff, fill_b_in;
   logic              active_ff, active_in;
   logic [ADDR_W-1:0] rpos_ff, rpos_in;

   logic              s1_v_ff;
   flags_type         s1_flags_ff;
   logic              s1_sel_ff;
   flags_type         flags_in;

   rsp_type           oq_ff [2];
   logic              oq_wr_ff, oq_rd_ff;
   logic [1:0]        oq_cnt_ff, oq_cnt_in;
   logic [1:0]        occ;
   logic              rsp_pop;
   rsp_type           oq_new;

   logic              issue;
   logic [FILL_W-1:0] fill_act, fill_back;
   logic [FILL_W-1:0] rpos_next;
   logic              full;
   logic              wr_en_a, wr_en_b, rd_en_a, rd_en_b, rd_en;
   logic [BYTE_W-1:0] rd_a, rd_b;

   // stage 1 plus output queue never hold more than two words
   assign rsp_pop = rsp_valid && rsp_ready;
   assign occ     = oq_cnt_ff + {1'b0, s1_v_ff};
   assign issue   = op_valid && ((occ != 2'd2) || rsp_pop);
   assign op_pop  = issue;

   assign fill_act  = active_ff ? fill_b_ff : fill_a_ff;
   assign fill_back = active_ff ? fill_a_ff : fill_b_ff;
   assign full      = (fill_act == FILL_W'(BUFFER_DEPTH));
   assign rpos_next = {1'b0, rpos_ff} + FILL_W'(1);

   always_comb begin
      fill_a_in = fill_a_ff;
      fill_b_in = fill_b_ff;
      active_in = active_ff;
      rpos_in   = rpos_ff;
      flags_in  = '0;
      rd_en     = 1'b0;
      if (issue) begin
         if (!op.is_read) begin
            if (full) begin
               flags_in.overflow = 1'b1;
            end else if (active_ff) begin
               fill_b_in = fill_b_ff + FILL_W'(1);
            end else begin
               fill_a_in = fill_a_ff + FILL_W'(1);
            end
            if (op.is_delim) begin
               // a partly read back line is thrown away on swap
               if (rpos_ff != '0) begin
                  if (active_ff) begin
                     fill_a_in = '0;
                  end else begin
                     fill_b_in = '0;
                  end
               end
               rpos_in            = '0;
               active_in          = ~active_ff;
               flags_in.line_done = 1'b1;
            end
         end else if (fill_back == '0) begin
            flags_in.back_empty = 1'b1;
         end else begin
            rd_en              = 1'b1;
            flags_in.out_valid = 1'b1;
            if (rpos_next >= fill_back) begin
               flags_in.out_last = 1'b1;
               rpos_in           = '0;
               if (active_ff) begin
                  fill_a_in = '0;
               end else begin
                  fill_b_in = '0;
               end
            end else begin
               rpos_in = rpos_next[ADDR_W-1:0];
            end
         end
      end
   end

   assign wr_en_a = issue && !op.is_read && !full && !active_ff;
   assign wr_en_b = issue && !op.is_read && !full && active_ff;
   assign rd_en_a = rd_en && active_ff;
   assign rd_en_b = rd_en && !active_ff;

   dlpp_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (fill_a_ff[ADDR_W-1:0]),
      .wr_data (op.data),
      .rd_en   (rd_en_a),
      .rd_addr (rpos_ff),
      .rd_data (rd_a)
   );

   dlpp_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (fill_b_ff[ADDR_W-1:0]),
      .wr_data (op.data),
      .rd_en   (rd_en_b),
      .rd_addr (rpos_ff),
      .rd_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_a_ff <= '0;
         fill_b_ff <= '0;
         active_ff <= 1'b0;
         rpos_ff   <= '0;
         s1_v_ff   <= 1'b0;
      end else begin
         fill_a_ff <= fill_a_in;
         fill_b_ff <= fill_b_in;
         active_ff <= active_in;
         rpos_ff   <= rpos_in;
         s1_v_ff   <= issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_flags_ff <= flags_in;
      s1_sel_ff   <= ~active_ff;
   end

   // read data lands in the cycle after issue
   always_comb begin
      oq_new.flags = s1_flags_ff;
      if (s1_flags_ff.out_valid) begin
         oq_new.data = s1_sel_ff ? rd_b : rd_a;
      end else begin
         oq_new.data = '0;
      end
   end

   assign oq_cnt_in = oq_cnt_ff + {1'b0, s1_v_ff} - {1'b0, rsp_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (s1_v_ff) begin
            oq_wr_ff <= ~oq_wr_ff;
         end
         if (rsp_pop) begin
            oq_rd_ff <= ~oq_rd_ff;
         end
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         oq_ff[oq_wr_ff] <= oq_new;
      end
   end

   assign rsp_valid = (oq_cnt_ff != 2'd0);
   assign rsp       = oq_ff[oq_rd_ff];

endmodule

/* rtl/delimited_line_ping_pong_buffer_unit.sv */
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser func, tdata in_byte
// rsp       out        rsp_tvalid/rsp_tready  tdata out_byte, tlast out_last, tuser flags
// csr       in         csr_wr_en              csr_wr_data delimiter
//
// one word per cycle sustained while the rsp side accepts; a word that is taken passes
// through the front queue, the registered line store read and the output queue before it leaves
// reset clears fills, read position, store select and delimiter (line feed)
// a stalled rsp side fills the output queue, then the front queue, then drops req_tready
module delimited_line_ping_pong_buffer_unit
   import dlpp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,   // [0] func
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,
   output logic [3:0]        rsp_tuser    // [0] out_valid [1] line_done [2] overflow [3] back_empty
);

   logic    op_valid;
   op_type  op;
   logic    op_pop;
   rsp_type rsp;

   dlpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_func    (req_tuser),
      .req_byte    (req_tdata),
      .op_valid    (op_valid),
      .op          (op),
      .op_pop      (op_pop)
   );

   dlpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .op_pop    (op_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = rsp.data;
   assign rsp_tlast = rsp.flags.out_last;
   assign rsp_tuser = {rsp.flags.back_empty, rsp.flags.overflow,
                       rsp.flags.line_done, rsp.flags.out_valid};

   a_last_is_read : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("last flag on a word without read data");

   a_read_write_apart : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |-> !(rsp_tuser[0] || rsp_tuser[3]))
      else $error("write and read flags on one word");

   a_pop_needs_op : assert property (@(posedge clock) disable iff (reset)
      op_pop |-> op_valid)
      else $error("back took a word from an empty front queue");

   a_empty_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("data byte on a word without read data");

endmodule
